// File: rtl/sstt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sstt_pkg;

    // Operation codes carried in the kind field
    localparam logic [2:0] KIND_ENABLE   = 3'd0;
    localparam logic [2:0] KIND_CREATE   = 3'd1;
    localparam logic [2:0] KIND_LOOKUP   = 3'd2;
    localparam logic [2:0] KIND_DELETE   = 3'd3;
    localparam logic [2:0] KIND_SWEEP    = 3'd4;
    localparam logic [2:0] KIND_SHUTDOWN = 3'd5;

    // Result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EXISTS    = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_NOT_READY = 3'd4;

    localparam logic [15:0] TIMEOUT_RESET = 16'd30;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] key;
        logic [31:0] now_time;
    } in_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] slot;
        logic [4:0] evicted_count;
        logic [4:0] occupancy;
    } out_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;   // latch the request beat, reset scan state
        logic issue;     // read the slot at the scan address, advance it
        logic finish;    // apply the operation, form the result
        logic load_out;  // move the result into the output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_scan;  // operation walks the slots
        logic last_addr;  // scan address sits on the last slot
        logic out_free;   // output register can take a result this cycle
    } stat_t;

endpackage

`default_nettype wire

// File: rtl/sstt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sstt_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire sstt_pkg::stat_t stat,
    output sstt_pkg::cmd_t      cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = stat.need_scan ? S_SCAN : S_FIN;
            end
            S_SCAN:
            begin
                cmd.issue = 1'b1;
                if (stat.last_addr)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/sstt_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module sstt_dp #(
    parameter int SLOTS = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire sstt_pkg::in_t  in_data,
    input  wire logic           cfg_we,
    input  wire logic [15:0]    cfg_wdata,
    input  wire sstt_pkg::cmd_t cmd,
    output sstt_pkg::stat_t     stat,
    output logic                out_valid,
    input  wire logic           out_stall,
    output sstt_pkg::out_t      out_data
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    // Slot storage: key and start time live in memories, valid bits in flops
    logic [15:0]      key_mem  [SLOTS];
    logic [31:0]      time_mem [SLOTS];
    logic [SLOTS-1:0] valid_reg;
    logic [SLOTS-1:0] valid_next;

    sstt_pkg::in_t    req_reg;
    logic             enabled_reg;
    logic             enabled_next;
    logic [CNT_W-1:0] total_reg;
    logic [CNT_W-1:0] total_next;
    logic [15:0]      timeout_reg;

    // Scan pipeline: address register, then read data registered from it
    logic [IDX_W-1:0] addr_reg;
    logic             eval_vld_reg;
    logic [IDX_W-1:0] eval_idx_reg;
    logic [15:0]      key_rd_reg;
    logic [31:0]      time_rd_reg;

    logic             hit_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic             free_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic [CNT_W-1:0] evict_cnt_reg;

    sstt_pkg::out_t   res_reg;
    sstt_pkg::out_t   res_next;
    logic             out_valid_reg;
    sstt_pkg::out_t   out_data_reg;

    logic             mem_we;
    logic             eval_live;
    logic             eval_hit;
    logic             eval_free;
    logic             eval_old;
    logic [31:0]      age;

    assign stat.need_scan = enabled_reg &&
                            ((req_reg.kind == sstt_pkg::KIND_CREATE) ||
                             (req_reg.kind == sstt_pkg::KIND_LOOKUP) ||
                             (req_reg.kind == sstt_pkg::KIND_DELETE) ||
                             (req_reg.kind == sstt_pkg::KIND_SWEEP));
    assign stat.last_addr = (addr_reg == IDX_W'(SLOTS - 1));
    assign stat.out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign age       = req_reg.now_time - time_rd_reg;
    assign eval_live = eval_vld_reg && valid_reg[eval_idx_reg];
    assign eval_hit  = eval_live && (key_rd_reg == req_reg.key);
    assign eval_free = eval_vld_reg && !valid_reg[eval_idx_reg];
    assign eval_old  = eval_live && (req_reg.kind == sstt_pkg::KIND_SWEEP) &&
                       (age > {16'd0, timeout_reg});

    always_comb
    begin
        valid_next   = valid_reg;
        total_next   = total_reg;
        enabled_next = enabled_reg;
        res_next     = res_reg;
        mem_we       = 1'b0;

        if (eval_old)
        begin
            valid_next[eval_idx_reg] = 1'b0;
            total_next               = total_reg - CNT_W'(1);
        end

        if (cmd.finish)
        begin
            res_next.status        = sstt_pkg::ST_OK;
            res_next.slot          = 4'd0;
            res_next.evicted_count = 5'd0;
            if (req_reg.kind == sstt_pkg::KIND_ENABLE)
            begin
                if (!enabled_reg)
                begin
                    valid_next   = '0;
                    total_next   = '0;
                    enabled_next = 1'b1;
                end
            end
            else if (!enabled_reg)
            begin
                res_next.status = sstt_pkg::ST_NOT_READY;
            end
            else
            begin
                unique case (req_reg.kind)
                    sstt_pkg::KIND_CREATE:
                    begin
                        if (hit_reg)
                        begin
                            res_next.status = sstt_pkg::ST_EXISTS;
                            res_next.slot   = 4'(hit_idx_reg);
                        end
                        else if (free_reg)
                        begin
                            mem_we                   = 1'b1;
                            valid_next[free_idx_reg] = 1'b1;
                            total_next               = total_reg + CNT_W'(1);
                            res_next.slot            = 4'(free_idx_reg);
                        end
                        else
                        begin
                            res_next.status = sstt_pkg::ST_FULL;
                        end
                    end
                    sstt_pkg::KIND_LOOKUP, sstt_pkg::KIND_DELETE:
                    begin
                        if (hit_reg)
                        begin
                            res_next.slot = 4'(hit_idx_reg);
                            if (req_reg.kind == sstt_pkg::KIND_DELETE)
                            begin
                                valid_next[hit_idx_reg] = 1'b0;
                                total_next              = total_reg - CNT_W'(1);
                            end
                        end
                        else
                        begin
                            res_next.status = sstt_pkg::ST_NOT_FOUND;
                        end
                    end
                    sstt_pkg::KIND_SWEEP:
                    begin
                        res_next.evicted_count = 5'(evict_cnt_reg);
                    end
                    sstt_pkg::KIND_SHUTDOWN:
                    begin
                        res_next.evicted_count = 5'(total_reg);
                        valid_next             = '0;
                        total_next             = '0;
                        enabled_next           = 1'b0;
                    end
                    default:
                    begin
                        res_next.status = sstt_pkg::ST_NOT_READY;
                    end
                endcase
            end
            res_next.occupancy = 5'(total_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[free_idx_reg]  <= req_reg.key;
            time_mem[free_idx_reg] <= req_reg.now_time;
        end
        if (cmd.issue)
        begin
            key_rd_reg  <= key_mem[addr_reg];
            time_rd_reg <= time_mem[addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= in_data;
        end
        if (cmd.issue)
        begin
            eval_idx_reg <= addr_reg;
        end
        if (eval_hit && !hit_reg)
        begin
            hit_idx_reg <= eval_idx_reg;
        end
        if (eval_free && !free_reg)
        begin
            free_idx_reg <= eval_idx_reg;
        end
        res_reg <= res_next;
        if (cmd.load_out)
        begin
            out_data_reg <= res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            total_reg     <= '0;
            enabled_reg   <= 1'b0;
            timeout_reg   <= sstt_pkg::TIMEOUT_RESET;
            addr_reg      <= '0;
            eval_vld_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            evict_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            total_reg    <= total_next;
            enabled_reg  <= enabled_next;
            eval_vld_reg <= cmd.issue;
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
            if (cmd.capture)
            begin
                addr_reg      <= '0;
                hit_reg       <= 1'b0;
                free_reg      <= 1'b0;
                evict_cnt_reg <= '0;
            end
            else
            begin
                if (cmd.issue)
                begin
                    addr_reg <= addr_reg + IDX_W'(1);
                end
                if (eval_hit)
                begin
                    hit_reg <= 1'b1;
                end
                if (eval_free)
                begin
                    free_reg <= 1'b1;
                end
                if (eval_old)
                begin
                    evict_cnt_reg <= evict_cnt_reg + CNT_W'(1);
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/session_slot_table_with_timeout.sv
// Session slot table with aging timeout. SLOTS slots each hold a 16-bit client
// key and a 32-bit start time. Enable clears and activates a disabled table
// and is a no-op on a live one; create returns the slot already holding the key
// or claims the lowest free slot and stamps it with now_time; lookup and delete
// search by key, lowest slot first; sweep evicts every slot whose wrapping age
// (now_time minus start) exceeds timeout_seconds; shutdown clears all slots and
// disables the table. On a disabled table everything but enable reports not
// ready. Each request beat yields exactly one result beat with status, slot,
// eviction count and occupancy. One request is handled at a time: create,
// lookup, delete and sweep walk the key/time memory at one slot per cycle;
// enable, shutdown and not-ready requests skip the walk. A finished result
// waits in the output register while the next request beat is taken.
// timeout_seconds resets to 30 and is written through cfg_we/cfg_wdata; the user
// must write it only while no request is in flight, and the block itself does
// not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module session_slot_table_with_timeout #(
    parameter int SLOTS = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire sstt_pkg::in_t  in_data,
    output logic                out_valid,
    input  wire logic           out_stall,
    output sstt_pkg::out_t      out_data,
    input  wire logic           cfg_we,
    input  wire logic [15:0]    cfg_wdata
);

    sstt_pkg::cmd_t  cmd;
    sstt_pkg::stat_t stat;

    // Sequence the scan: capture, decide, walk the slots, drain, apply, emit
    sstt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold slot storage, scan trackers, counters and the output register
    sstt_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // One request in flight: an accepted beat closes the input side
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while a request is in flight");

    // Not ready reports carry no slot and no evictions
    a_not_ready_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.status == sstt_pkg::ST_NOT_READY)) |->
        ((out_data.slot == 4'd0) && (out_data.evicted_count == 5'd0)))
        else $error("not ready result with slot or evictions");

    // Table full only when every slot is occupied
    a_full_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.status == sstt_pkg::ST_FULL)) |->
        (out_data.occupancy == 5'(SLOTS)))
        else $error("table full reported below capacity");

    // Occupancy never exceeds the slot count
    a_occupancy_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((SLOTS > 31) || (out_data.occupancy <= 5'(SLOTS))))
        else $error("occupancy above slot count");

endmodule

`default_nettype wire

// File: bench/session_slot_table_with_timeout_test.sv
`timescale 1ns / 1ps

module session_slot_table_with_timeout_test;

    import sstt_pkg::*;

    localparam int SLOTS        = 16;
    localparam int KEY_POOL     = 24;    // few keys, so creates collide and lookups hit
    localparam int DRAIN_CYCLES = 32;    // the longest request is a full slot walk
    localparam int STUCK_LIMIT  = 4000;  // cycles with no beat on either side

    // Block ports. Every input holds a known value from time zero.
    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  in_valid  = 1'b0;
    in_t   in_data   = '0;
    logic  out_stall = 1'b0;
    logic  cfg_we    = 1'b0;
    logic  [15:0] cfg_wdata = '0;
    logic  in_stall;
    logic  out_valid;
    out_t  out_data;

    // Requests waiting to be sent, and results owed by the block in order.
    in_t   pending_ops[$];
    out_t  owed_results[$];

    // Shadow copy of the slot table, advanced once per accepted request beat.
    logic [SLOTS-1:0] tbl_valid;
    logic [15:0]      tbl_key[SLOTS];
    logic [31:0]      tbl_start[SLOTS];
    int               tbl_count;
    bit               tbl_on;
    logic [15:0]      tbl_timeout;

    // Request generator state: key pool, running clock, and whether the
    // generated sequence expects the table to be enabled.
    logic [15:0] key_pool[KEY_POOL];
    logic [31:0] gen_clock;
    logic [31:0] gen_step;
    bit          gen_on;

    // Idle control for both sides; quiet turns all idling off.
    bit  quiet;
    int  send_gap;
    int  stall_left;
    int  bad_count;
    int  stuck_cycles;

    session_slot_table_with_timeout #(
        .SLOTS(SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #1 clk = ~clk;

    // Apply one request to the shadow table and return the result it owes.
    function automatic out_t apply_session_op(input in_t op);
        out_t        r;
        int          hit;
        int          free_slot;
        int          evicted;
        logic [31:0] age;
        r = '0;
        r.status = ST_OK;
        hit = -1;
        free_slot = -1;
        evicted = 0;
        // Walk downward so the lowest matching and lowest free slot win.
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (tbl_valid[i] && tbl_key[i] == op.key)
                hit = i;
            if (!tbl_valid[i])
                free_slot = i;
        end
        if (op.kind == KIND_ENABLE)
        begin
            // Enable on a live table is a no-op; on a dead one it clears first.
            if (!tbl_on)
            begin
                tbl_valid = '0;
                tbl_count = 0;
                tbl_on = 1'b1;
            end
        end
        else if (op.kind > KIND_SHUTDOWN || !tbl_on)
        begin
            r.status = ST_NOT_READY;
        end
        else
        begin
            case (op.kind)
                KIND_CREATE:
                begin
                    if (hit >= 0)
                    begin
                        // Existing key: report it, keep the old start time.
                        r.status = ST_EXISTS;
                        r.slot = 4'(hit);
                    end
                    else if (free_slot < 0)
                    begin
                        r.status = ST_FULL;
                    end
                    else
                    begin
                        tbl_valid[free_slot] = 1'b1;
                        tbl_key[free_slot] = op.key;
                        tbl_start[free_slot] = op.now_time;
                        tbl_count++;
                        r.slot = 4'(free_slot);
                    end
                end
                KIND_LOOKUP, KIND_DELETE:
                begin
                    if (hit < 0)
                    begin
                        r.status = ST_NOT_FOUND;
                    end
                    else
                    begin
                        r.slot = 4'(hit);
                        if (op.kind == KIND_DELETE)
                        begin
                            tbl_valid[hit] = 1'b0;
                            tbl_count--;
                        end
                    end
                end
                KIND_SWEEP:
                begin
                    // Age wraps at 32 bits; evict strictly past the timeout.
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        age = op.now_time - tbl_start[i];
                        if (tbl_valid[i] && age > {16'd0, tbl_timeout})
                        begin
                            tbl_valid[i] = 1'b0;
                            tbl_count--;
                            evicted++;
                        end
                    end
                end
                default:
                begin
                    // Shutdown: drop every slot and disable.
                    evicted = tbl_count;
                    tbl_valid = '0;
                    tbl_count = 0;
                    tbl_on = 1'b0;
                end
            endcase
        end
        r.evicted_count = 5'(evicted);
        r.occupancy = 5'(tbl_count);
        return r;
    endfunction

    // Build one random request. Most of the stream is well-formed work on an
    // enabled table; a disabled table is usually re-enabled at once.
    function automatic in_t next_session_op();
        in_t op;
        int  pick;
        op.key = key_pool[$urandom_range(0, KEY_POOL - 1)];
        if ($urandom_range(0, 19) == 0)
            op.key = 16'($urandom);
        gen_clock = gen_clock + $urandom_range(0, gen_step);
        op.now_time = gen_clock;
        if ($urandom_range(0, 19) == 0)
            op.now_time = $urandom;
        pick = $urandom_range(0, 99);
        if (!gen_on && pick < 75)
            pick = 0;
        if (pick < 3)
            op.kind = KIND_ENABLE;
        else if (pick < 45)
            op.kind = KIND_CREATE;
        else if (pick < 65)
            op.kind = KIND_LOOKUP;
        else if (pick < 80)
            op.kind = KIND_DELETE;
        else if (pick < 94)
            op.kind = KIND_SWEEP;
        else if (pick < 97)
            op.kind = KIND_SHUTDOWN;
        else
            op.kind = KIND_SHUTDOWN + 3'($urandom_range(1, 2));
        if (op.kind == KIND_ENABLE)
            gen_on = 1'b1;
        else if (op.kind == KIND_SHUTDOWN)
            gen_on = 1'b0;
        return op;
    endfunction

    task automatic push_op(input logic [2:0] kind, input logic [15:0] key,
                           input logic [31:0] now_time);
        in_t op;
        op.kind = kind;
        op.key = key;
        op.now_time = now_time;
        pending_ops.push_back(op);
    endtask

    task automatic queue_random_ops(input int count);
        repeat (count)
            pending_ops.push_back(next_session_op());
    endtask

    // Wait until every request is sent and every owed result has come back,
    // then let the block settle. Check at the falling edge, where all is stable.
    task automatic drain_block();
        while (pending_ops.size() != 0 || in_valid || owed_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write the timeout register; only called with the block idle.
    task automatic write_timeout(input logic [15:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        tbl_timeout = value;
        // Scale time steps to the timeout so sweeps evict now and then.
        gen_step = {16'd0, value} / 4 + 2;
        @(negedge clk);
    endtask

    task automatic note_failure(input bit has_want, input out_t want, input out_t got);
        bad_count++;
        if (bad_count <= 10)
        begin
            if (has_want)
                $display("mismatch at %0t: expected status %0d slot %0d evicted %0d occ %0d,",
                         $realtime, want.status, want.slot, want.evicted_count,
                         want.occupancy);
            else
                $display("unexpected result beat at %0t with nothing owed,", $realtime);
            $display("    got status %0d slot %0d evicted %0d occ %0d",
                     got.status, got.slot, got.evicted_count, got.occupancy);
        end
    endtask

    // Request driver: predict each accepted beat, hold a stalled beat, then
    // either open an idle burst or present the next pending request.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                owed_results.push_back(apply_session_op(in_data));
            if (!(in_valid && in_stall))
            begin
                if (send_gap > 0)
                begin
                    send_gap = send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_ops.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (!quiet && $urandom_range(0, 7) == 0)
                begin
                    send_gap = $urandom_range(1, 14) - 1;
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_data <= pending_ops.pop_front();
                    in_valid <= 1'b1;
                end
            end
        end
    end

    // Result monitor: check each accepted beat against the oldest owed
    // result, and stall the output in random bursts.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (owed_results.size() == 0)
                note_failure(1'b0, '0, out_data);
            else if (owed_results[0].status !== out_data.status ||
                     owed_results[0].slot !== out_data.slot ||
                     owed_results[0].evicted_count !== out_data.evicted_count ||
                     owed_results[0].occupancy !== out_data.occupancy)
                note_failure(1'b1, owed_results.pop_front(), out_data);
            else
                void'(owed_results.pop_front());
        end
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 6) == 0)
        begin
            stall_left = $urandom_range(1, 14) - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Count cycles in which no beat moves on either side.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin
        wait (stuck_cycles >= STUCK_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        tbl_valid = '0;
        tbl_count = 0;
        tbl_on = 1'b0;
        tbl_timeout = TIMEOUT_RESET;
        gen_clock = $urandom;
        gen_step = 10;
        gen_on = 1'b0;
        quiet = 1'b0;
        bad_count = 0;
        stuck_cycles = 0;
        foreach (tbl_key[i])
        begin
            tbl_key[i] = '0;
            tbl_start[i] = '0;
        end
        // Key pool keeps both extreme keys plus random ones.
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;
        for (int i = 2; i < KEY_POOL; i++)
            key_pool[i] = 16'($urandom);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset timeout of 30 seconds.
        // Disabled table: everything but enable reports not ready.
        push_op(KIND_LOOKUP, 16'd5, 32'd0);
        push_op(KIND_SWEEP, 16'd0, 32'd1000);
        push_op(KIND_SHUTDOWN, 16'd0, 32'd0);
        push_op(KIND_SHUTDOWN + 3'd1, 16'hFFFF, 32'hFFFF_FFFF);
        push_op(KIND_SHUTDOWN + 3'd2, 16'd0, 32'd0);
        // Enable, then enable again on a live table.
        push_op(KIND_ENABLE, 16'd0, 32'd0);
        push_op(KIND_ENABLE, 16'hFFFF, 32'hFFFF_FFFF);
        // Create, duplicate create without restamp, lookup hit and miss.
        push_op(KIND_CREATE, 16'h0000, 32'd100);
        push_op(KIND_CREATE, 16'hFFFF, 32'd110);
        push_op(KIND_CREATE, 16'h0000, 32'd200);
        push_op(KIND_LOOKUP, 16'hFFFF, 32'd0);
        push_op(KIND_LOOKUP, 16'h1234, 32'd0);
        // Delete frees the slot; a second delete misses; create reuses it.
        push_op(KIND_DELETE, 16'h0000, 32'd0);
        push_op(KIND_DELETE, 16'h0000, 32'd0);
        push_op(KIND_CREATE, 16'h00AA, 32'd120);
        // Age exactly at the timeout stays, one past it goes.
        push_op(KIND_SWEEP, 16'd0, 32'd140);
        push_op(KIND_SWEEP, 16'd0, 32'd141);
        // Start near the top of the clock, sweep after it wraps.
        push_op(KIND_CREATE, 16'h0007, 32'hFFFF_FFF0);
        push_op(KIND_SWEEP, 16'd0, 32'd5);
        // Shutdown counts what it drops; then the table is dead until enabled.
        push_op(KIND_SHUTDOWN, 16'd0, 32'd0);
        push_op(KIND_CREATE, 16'h0009, 32'd0);
        push_op(KIND_ENABLE, 16'd0, 32'd0);
        push_op(KIND_LOOKUP, 16'h0007, 32'd0);
        drain_block();

        // Random phases across timeout settings, extremes first.
        write_timeout(16'h0000);
        queue_random_ops(300);
        drain_block();

        write_timeout(16'hFFFF);
        gen_clock = 32'hFFF0_0000;
        queue_random_ops(350);
        drain_block();

        write_timeout(16'($urandom));
        queue_random_ops(350);
        drain_block();

        // Final phase runs at full rate on both sides.
        write_timeout(16'($urandom_range(1, 60)));
        quiet = 1'b1;
        queue_random_ops(350);
        drain_block();

        if (owed_results.size() != 0)
            bad_count++;
        if (bad_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
